// File: hdl/red_ecn_marker_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef RED_ECN_MARKER_ASSERT_SVH
`define RED_ECN_MARKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RECM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RECM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/recm_pkg.sv
`timescale 1ns / 1ps

package recm_pkg;

   localparam logic [16:0] ONE_Q16  = 17'd65536;
   localparam logic [16:0] HALF_Q16 = 17'd32768;

   // Quotient bits of the interpolation divide.
   localparam int DIV_STEPS = 17;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROB_AT_MIN   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROB_AT_MAX   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_AVG_WEIGHT    = 3'd4;

   localparam logic [15:0] RST_MIN_THRESHOLD = 16'd5;
   localparam logic [15:0] RST_MAX_THRESHOLD = 16'd15;
   localparam logic [16:0] RST_PROB_AT_MIN   = 17'd0;
   localparam logic [16:0] RST_PROB_AT_MAX   = 17'd6554;
   localparam logic [16:0] RST_AVG_WEIGHT    = 17'd131;

   typedef struct packed {
      logic        mode;
      logic [15:0] queue_length;
      logic [31:0] now_ms;
      logic [15:0] random_value;
      logic        has_tcp_ip;
   } req_type;

   typedef struct packed {
      logic        mark_congestion;
      logic        cannot_mark;
      logic [16:0] drop_probability;
      logic [31:0] average_queue;
      logic [31:0] mark_total;
   } rsp_type;

   typedef struct packed {
      logic take_note;
      logic take_pkt;
      logic lin_a;
      logic lin_b;
      logic lin_c;
      logic pow_mul;
      logic pow_upd;
      logic avg_mul;
      logic avg_upd;
      logic prob;
      logic div_load;
      logic div_step;
      logic div_end;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic note;
      logic len_zero;
      logic between;
      logic out_free;
   } stat_type;

endpackage

// File: hdl/recm_datapath.sv
`timescale 1ns / 1ps

module recm_datapath #(
   parameter int QUEUE_BITS    = 16,
   parameter int IDLE_EXP_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  recm_pkg::req_type                    req_data,
   input  logic                                 csr_write_en,
   input  logic [recm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [recm_pkg::CSR_DATA_W-1:0]      csr_data,
   input  recm_pkg::cmd_type                    cmd,
   output recm_pkg::stat_type                   stat,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output recm_pkg::rsp_type                    rsp_data
);

   localparam int LEN_W = (QUEUE_BITS < 16) ? QUEUE_BITS : 16;

   logic [15:0] min_th_ff, max_th_ff;
   logic [16:0] pmin_raw_ff, pmax_raw_ff, weight_raw_ff;

   logic [31:0]              avg_ff, empty_ff, count_ff;
   logic [LEN_W-1:0]         len_ff;
   logic [16:0]              prob_ff;
   logic [15:0]              rnd_ff;
   logic                     tcp_ff;
   logic [48:0]              prod_ff, acc_ff;
   logic [33:0]              sq_ff;
   logic [16:0]              r_ff, base_ff;
   logic [IDLE_EXP_BITS-1:0] exp_ff;
   logic [31:0]              rem_ff;
   logic [16:0]              dvd_ff, quo_ff;
   logic                     rsp_valid_ff;
   recm_pkg::rsp_type        rsp_data_ff;

   logic [16:0]              weight, inv_weight, pmin, pmax, pdiff, prob_sel;
   logic [31:0]              lo, hi, off, span, elapsed;
   logic [IDLE_EXP_BITS-1:0] exp_sat;
   logic [31:0]              mul_a;
   logic [16:0]              mul_b;
   logic [48:0]              mul_p;
   logic [49:0]              lin_sum, avg_sum;
   logic [32:0]              trial;
   logic                     trial_ge, between, pmax_ge, mark_sel, out_free;
   logic [LEN_W-1:0]         new_len;
   logic [31:0]              count_in;

   function automatic logic [16:0] clamp_one(input logic [16:0] v);
      return (v > recm_pkg::ONE_Q16) ? recm_pkg::ONE_Q16 : v;
   endfunction

   // Q1.16 product rounded half up.
   function automatic logic [16:0] round_q16(input logic [33:0] x);
      logic [33:0] s;
      s = x + 34'(recm_pkg::HALF_Q16);
      return s[32:16];
   endfunction

   function automatic logic [31:0] sat_avg(input logic [49:0] s);
      return (|s[49:48]) ? 32'hFFFF_FFFF : s[47:16];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         min_th_ff     <= recm_pkg::RST_MIN_THRESHOLD;
         max_th_ff     <= recm_pkg::RST_MAX_THRESHOLD;
         pmin_raw_ff   <= recm_pkg::RST_PROB_AT_MIN;
         pmax_raw_ff   <= recm_pkg::RST_PROB_AT_MAX;
         weight_raw_ff <= recm_pkg::RST_AVG_WEIGHT;
      end else if (csr_write_en) begin
         case (csr_index)
            recm_pkg::CSR_MIN_THRESHOLD: min_th_ff     <= csr_data[15:0];
            recm_pkg::CSR_MAX_THRESHOLD: max_th_ff     <= csr_data[15:0];
            recm_pkg::CSR_PROB_AT_MIN:   pmin_raw_ff   <= csr_data;
            recm_pkg::CSR_PROB_AT_MAX:   pmax_raw_ff   <= csr_data;
            recm_pkg::CSR_AVG_WEIGHT:    weight_raw_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      weight     = clamp_one(weight_raw_ff);
      inv_weight = recm_pkg::ONE_Q16 - weight;
      pmin       = clamp_one(pmin_raw_ff);
      pmax       = clamp_one(pmax_raw_ff);
      pmax_ge    = (pmax >= pmin);
      pdiff      = pmax_ge ? (pmax - pmin) : (pmin - pmax);
      lo         = {min_th_ff, 16'd0};
      hi         = {max_th_ff, 16'd0};
      off        = avg_ff - lo;
      span       = hi - lo;
      between    = (avg_ff > lo) && (avg_ff < hi);
      elapsed    = req_data.now_ms - empty_ff;
      exp_sat    = (|elapsed[31:IDLE_EXP_BITS]) ? '1 : elapsed[IDLE_EXP_BITS-1:0];
      new_len    = req_data.queue_length[LEN_W-1:0];

      // Later tests win, as in the sequential definition of the curve.
      prob_sel = prob_ff;
      if (avg_ff < lo) begin
         prob_sel = '0;
      end
      if (avg_ff == lo) begin
         prob_sel = pmin;
      end
      if (avg_ff == hi) begin
         prob_sel = pmax;
      end
      if (avg_ff > hi) begin
         prob_sel = recm_pkg::ONE_Q16;
      end

      mul_a = '0;
      mul_b = '0;
      if (cmd.lin_a) begin
         mul_a = avg_ff;
         mul_b = inv_weight;
      end else if (cmd.lin_b) begin
         mul_a = 32'(len_ff);
         mul_b = weight;
      end else if (cmd.pow_mul) begin
         mul_a = {15'd0, r_ff};
         mul_b = base_ff;
      end else if (cmd.avg_mul) begin
         mul_a = avg_ff;
         mul_b = r_ff;
      end else if (cmd.prob) begin
         mul_a = off;
         mul_b = pdiff;
      end
      mul_p = {17'd0, mul_a} * {32'd0, mul_b};

      lin_sum = {1'b0, acc_ff} + {1'b0, prod_ff[32:0], 16'd0} + 50'(recm_pkg::HALF_Q16);
      avg_sum = {1'b0, prod_ff} + 50'(recm_pkg::HALF_Q16);

      trial    = {rem_ff, dvd_ff[16]};
      trial_ge = (trial >= {1'b0, span});

      mark_sel = ({1'b0, rnd_ff} < prob_ff);
      count_in = count_ff + {31'd0, mark_sel && tcp_ff};
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff       <= '0;
         len_ff       <= '0;
         empty_ff     <= '0;
         prob_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.take_note) begin
            len_ff <= new_len;
            if (new_len == '0) begin
               empty_ff <= req_data.now_ms;
            end
         end
         if (cmd.lin_c) begin
            avg_ff <= sat_avg(lin_sum);
         end
         if (cmd.avg_upd) begin
            avg_ff <= sat_avg(avg_sum);
         end
         if (cmd.prob && !between) begin
            prob_ff <= prob_sel;
         end
         if (cmd.div_end) begin
            prob_ff <= pmax_ge ? (pmin + quo_ff) : (pmin - quo_ff);
         end
         if (cmd.emit) begin
            count_ff <= count_in;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      sq_ff   <= {17'd0, base_ff} * {17'd0, base_ff};
      if (cmd.take_pkt) begin
         rnd_ff  <= req_data.random_value;
         tcp_ff  <= req_data.has_tcp_ip;
         r_ff    <= recm_pkg::ONE_Q16;
         base_ff <= inv_weight;
         exp_ff  <= exp_sat;
      end
      if (cmd.lin_b) begin
         acc_ff <= prod_ff;
      end
      if (cmd.pow_upd) begin
         if (exp_ff[0]) begin
            r_ff <= round_q16(prod_ff[33:0]);
         end
         base_ff <= round_q16(sq_ff);
         exp_ff  <= exp_ff >> 1;
      end
      // The top of the dividend is already below the span, so each step
      // yields one quotient bit.
      if (cmd.div_load) begin
         rem_ff <= prod_ff[48:17];
         dvd_ff <= prod_ff[16:0];
         quo_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= trial_ge ? 32'(trial - {1'b0, span}) : trial[31:0];
         dvd_ff <= {dvd_ff[15:0], 1'b0};
         quo_ff <= {quo_ff[15:0], trial_ge};
      end
      if (cmd.emit) begin
         rsp_data_ff.mark_congestion  <= mark_sel && tcp_ff;
         rsp_data_ff.cannot_mark      <= mark_sel && !tcp_ff;
         rsp_data_ff.drop_probability <= prob_ff;
         rsp_data_ff.average_queue    <= avg_ff;
         rsp_data_ff.mark_total       <= count_in;
      end
   end

   assign stat.note     = req_data.mode;
   assign stat.len_zero = (len_ff == '0);
   assign stat.between  = between;
   assign stat.out_free = out_free;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

endmodule

// File: hdl/recm_control.sv
`timescale 1ns / 1ps

module recm_control #(
   parameter int IDLE_EXP_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  recm_pkg::stat_type stat,
   output recm_pkg::cmd_type  cmd
);

   localparam int CNT_MAX = (IDLE_EXP_BITS > recm_pkg::DIV_STEPS) ?
                            IDLE_EXP_BITS : recm_pkg::DIV_STEPS;
   localparam int CNT_W   = $clog2(CNT_MAX);

   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0000000000001,
      ST_LIN_A    = 13'b0000000000010,
      ST_LIN_B    = 13'b0000000000100,
      ST_LIN_C    = 13'b0000000001000,
      ST_POW_MUL  = 13'b0000000010000,
      ST_POW_UPD  = 13'b0000000100000,
      ST_AVG_MUL  = 13'b0000001000000,
      ST_AVG_UPD  = 13'b0000010000000,
      ST_PROB     = 13'b0000100000000,
      ST_DIV_LOAD = 13'b0001000000000,
      ST_DIV_STEP = 13'b0010000000000,
      ST_DIV_END  = 13'b0100000000000,
      ST_EMIT     = 13'b1000000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (stat.note) begin
                  cmd.take_note = 1'b1;
               end else begin
                  cmd.take_pkt = 1'b1;
                  cnt_in       = '0;
                  state_in     = stat.len_zero ? ST_POW_MUL : ST_LIN_A;
               end
            end
         end
         ST_LIN_A: begin
            cmd.lin_a = 1'b1;
            state_in  = ST_LIN_B;
         end
         ST_LIN_B: begin
            cmd.lin_b = 1'b1;
            state_in  = ST_LIN_C;
         end
         ST_LIN_C: begin
            cmd.lin_c = 1'b1;
            state_in  = ST_PROB;
         end
         ST_POW_MUL: begin
            cmd.pow_mul = 1'b1;
            state_in    = ST_POW_UPD;
         end
         ST_POW_UPD: begin
            cmd.pow_upd = 1'b1;
            if (cnt_ff == CNT_W'(IDLE_EXP_BITS - 1)) begin
               cnt_in   = '0;
               state_in = ST_AVG_MUL;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_POW_MUL;
            end
         end
         ST_AVG_MUL: begin
            cmd.avg_mul = 1'b1;
            state_in    = ST_AVG_UPD;
         end
         ST_AVG_UPD: begin
            cmd.avg_upd = 1'b1;
            state_in    = ST_PROB;
         end
         ST_PROB: begin
            cmd.prob = 1'b1;
            state_in = stat.between ? ST_DIV_LOAD : ST_EMIT;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(recm_pkg::DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_DIV_END;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV_END: begin
            cmd.div_end = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/red_ecn_marker.sv
`timescale 1ns / 1ps
// Channel   Ports                              Moves
// -------   --------------------------------   --------------------------------------
// request   req_valid, req_ready, req_data     packet or queue length notification
// response  rsp_valid, rsp_ready, rsp_data     mark decision, probability, average
// csr       csr_write_en, csr_index, csr_data  threshold, probability, weight writes
//
// Notifications are taken without leaving the idle state and give no response. A
// packet's response passes the average update, the probability step and, when the
// average lies inside the interpolation band, the divider, taking 17 steps; with an
// empty queue the update is a power loop of a multiply and an update step for each exponent bit.
// Reset is synchronous. A finished result waits in the response register while the
// next request is taken; a packet stalls only at its emit step.

module red_ecn_marker #(
   parameter int QUEUE_BITS    = 16,
   parameter int IDLE_EXP_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  recm_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output recm_pkg::rsp_type                rsp_data,
   input  logic                             csr_write_en,
   input  logic [recm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [recm_pkg::CSR_DATA_W-1:0]  csr_data
);

   recm_pkg::cmd_type  cmd;
   recm_pkg::stat_type stat;

   recm_control #(
      .IDLE_EXP_BITS(IDLE_EXP_BITS)
   ) u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   recm_datapath #(
      .QUEUE_BITS    (QUEUE_BITS),
      .IDLE_EXP_BITS (IDLE_EXP_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

// File: hdl/recm_checker.sv
`timescale 1ns / 1ps
`include "red_ecn_marker_assert.svh"

module recm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input recm_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input recm_pkg::rsp_type rsp_data
);

   logic both_flags, marked_at_zero, pkt_taken, rsp_stalled;

   assign both_flags     = rsp_data.mark_congestion && rsp_data.cannot_mark;
   assign marked_at_zero = rsp_data.mark_congestion && (rsp_data.drop_probability == 17'd0);
   assign pkt_taken      = req_valid && req_ready && !req_data.mode;
   assign rsp_stalled    = rsp_valid && !rsp_ready;

   `RECM_ASSERT_NOW(a_mark_excl, clock, reset, rsp_valid, !both_flags, "both result flags set")

   `RECM_ASSERT_NOW(a_mark_prob, clock, reset, rsp_valid, !marked_at_zero, "zero-probability mark")

   `RECM_ASSERT_NEXT(a_pkt_busy, clock, reset, pkt_taken, !req_ready, "request channel open")

   `RECM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid, "response withdrawn")

endmodule

bind red_ecn_marker recm_checker u_recm_checker (.*);
